// ===== src/iou_pkg.sv =====
// Package for the box intersection-over-union block: default widths and the
// tag that travels with each word down the pipeline.
// No dependencies.
`default_nettype none

package iou_pkg;

  // Default width of a signed box coordinate; sizes are one bit narrower.
  localparam int unsigned COORD_BITS_DEF = 16;
  // Default number of fraction bits in the ratio.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Control bits that accompany a word from stage to stage.
  typedef struct packed {
    logic valid;
    logic empty;
  } iou_tag_t;

endpackage

`default_nettype wire

// ===== src/iou_if.sv =====
// Valid/ready channel interfaces for the box pair input and the ratio output.
// Depends on iou_pkg for the default widths.
`default_nettype none

interface iou_in_if #(
  parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_left;
  logic signed [COORD_BITS-1:0] first_top;
  logic        [COORD_BITS-2:0] first_width;
  logic        [COORD_BITS-2:0] first_height;
  logic signed [COORD_BITS-1:0] second_left;
  logic signed [COORD_BITS-1:0] second_top;
  logic        [COORD_BITS-2:0] second_width;
  logic        [COORD_BITS-2:0] second_height;

  modport source (
    output valid, first_left, first_top, first_width, first_height,
           second_left, second_top, second_width, second_height,
    input  ready
  );
  modport sink (
    input  valid, first_left, first_top, first_width, first_height,
           second_left, second_top, second_width, second_height,
    output ready
  );
endinterface

interface iou_out_if #(
  parameter int unsigned FRACTION_BITS = iou_pkg::FRACTION_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS:0]   overlap_ratio;
  logic                     union_empty;

  modport source (output valid, overlap_ratio, union_empty, input ready);
  modport sink   (input valid, overlap_ratio, union_empty, output ready);
endinterface

`default_nettype wire

// ===== src/iou_front.sv =====
// Front end of the ratio pipeline: overlap extents, the three areas and the
// union, over three registered stages. Depends on iou_pkg and iou_if.
`default_nettype none

module iou_front #(
  parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  iou_in_if.sink                    pair_i,
  output iou_pkg::iou_tag_t         tag_o,
  input  logic                      ready_i,
  output logic [2*COORD_BITS-3:0]   inter_o,
  output logic [2*COORD_BITS-2:0]   union_sum_o
);
  import iou_pkg::*;

  localparam int unsigned SW = COORD_BITS - 1;   // size width
  localparam int unsigned EW = COORD_BITS + 2;   // edge arithmetic width
  localparam int unsigned PW = 2 * SW;           // product width
  localparam int unsigned UW = PW + 1;           // union width

  function automatic logic [SW-1:0] extent(input logic signed [EW-1:0] a0,
                                           input logic signed [EW-1:0] a1,
                                           input logic signed [EW-1:0] b0,
                                           input logic signed [EW-1:0] b1);
    logic signed [EW-1:0] lo;
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] d;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    return (hi > lo) ? d[SW-1:0] : '0;
  endfunction

  logic signed [EW-1:0] l1, r1, t1, b1, l2, r2, t2, b2;
  logic                 empty_d;
  logic                 rdy1, rdy2, rdy3;

  iou_tag_t             s1_tag_q, s2_tag_q, s3_tag_q;
  logic [SW-1:0]        iw_q, ih_q, w1_q, h1_q, w2_q, h2_q;
  logic [PW-1:0]        inter2_q, area1_q, area2_q;
  logic [PW-1:0]        inter3_q;
  logic [UW-1:0]        union_q;
  logic [UW-1:0]        union_d;

  always_comb begin
    l1 = EW'(pair_i.first_left);
    t1 = EW'(pair_i.first_top);
    l2 = EW'(pair_i.second_left);
    t2 = EW'(pair_i.second_top);
    r1 = l1 + $signed(EW'(pair_i.first_width));
    b1 = t1 + $signed(EW'(pair_i.first_height));
    r2 = l2 + $signed(EW'(pair_i.second_width));
    b2 = t2 + $signed(EW'(pair_i.second_height));
    // The union is never below the larger area, so it is empty exactly when
    // both boxes have no area.
    empty_d = ((pair_i.first_width == '0) || (pair_i.first_height == '0)) &&
              ((pair_i.second_width == '0) || (pair_i.second_height == '0));
    union_d = UW'(area1_q) + UW'(area2_q) - UW'(inter2_q);
  end

  assign rdy3         = !s3_tag_q.valid || ready_i;
  assign rdy2         = !s2_tag_q.valid || rdy3;
  assign rdy1         = !s1_tag_q.valid || rdy2;
  assign pair_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else begin
      if (rdy1) begin
        s1_tag_q <= '{valid: pair_i.valid, empty: empty_d};
      end
      if (rdy2) begin
        s2_tag_q <= s1_tag_q;
      end
      if (rdy3) begin
        s3_tag_q <= s2_tag_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      iw_q <= extent(l1, r1, l2, r2);
      ih_q <= extent(t1, b1, t2, b2);
      w1_q <= pair_i.first_width;
      h1_q <= pair_i.first_height;
      w2_q <= pair_i.second_width;
      h2_q <= pair_i.second_height;
    end
    if (rdy2) begin
      inter2_q <= iw_q * ih_q;
      area1_q  <= w1_q * h1_q;
      area2_q  <= w2_q * h2_q;
    end
    if (rdy3) begin
      inter3_q <= inter2_q;
      union_q  <= union_d;
    end
  end

  assign tag_o       = s3_tag_q;
  assign inter_o     = inter3_q;
  assign union_sum_o = union_q;

  a_inter_le_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_tag_q.valid |-> (UW'(inter3_q) <= union_q))
    else $error("intersection exceeds union");

  a_empty_zero_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_tag_q.valid && s3_tag_q.empty) |-> (union_q == '0))
    else $error("empty flag set with nonzero union");

  a_full_union_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_tag_q.valid && !s3_tag_q.empty) |-> (union_q != '0))
    else $error("zero union without empty flag");

endmodule

`default_nettype wire

// ===== src/iou_div_cell.sv =====
// One cell of the restoring divider chain: a single quotient bit per cell,
// with its own valid/ready stage. Depends on iou_pkg.
`default_nettype none

module iou_div_cell #(
  parameter int unsigned REM_BITS   = 2 * iou_pkg::COORD_BITS_DEF - 1,
  parameter int unsigned RATIO_BITS = iou_pkg::FRACTION_BITS_DEF + 1,
  parameter bit          FIRST_STEP = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iou_pkg::iou_tag_t     tag_i,
  output logic                  ready_o,
  input  logic [REM_BITS-1:0]   rem_i,
  input  logic [REM_BITS-1:0]   den_i,
  input  logic [RATIO_BITS-1:0] q_i,
  output iou_pkg::iou_tag_t     tag_o,
  input  logic                  ready_i,
  output logic [REM_BITS-1:0]   rem_o,
  output logic [REM_BITS-1:0]   den_o,
  output logic [RATIO_BITS-1:0] q_o
);
  import iou_pkg::*;

  iou_tag_t              tag_q;
  logic [REM_BITS-1:0]   rem_q, rem_d, den_q;
  logic [RATIO_BITS-1:0] q_q, q_d;
  logic [REM_BITS:0]     trial, diff;
  logic                  ge;

  // The first cell compares the numerator as it stands; later cells shift
  // the partial remainder by one place first.
  always_comb begin
    trial = FIRST_STEP ? {1'b0, rem_i} : {rem_i, 1'b0};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
    q_d   = FIRST_STEP ? RATIO_BITS'(ge) : {q_i[RATIO_BITS-2:0], ge};
  end

  assign ready_o = !tag_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (ready_o) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q <= rem_d;
      den_q <= den_i;
      q_q   <= q_d;
    end
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_q.valid && (den_q != '0)) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== src/box_intersection_over_union.sv =====
// An accepted box pair passes three front stages, then one cell per quotient
// bit, on its way to the output. Throughput: one pair per cycle while the
// output is not held back, since the divider chain takes one quotient bit
// per cell. Reset clears only the stage tags, valid and empty flags alike;
// payload registers keep whatever they hold. Depends on iou_pkg, iou_if,
// iou_front and iou_div_cell.
`default_nettype none

module box_intersection_over_union #(
  parameter int unsigned COORD_BITS    = iou_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = iou_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iou_in_if.sink     pair_i,
  iou_out_if.source  result_o
);
  import iou_pkg::*;

  // Intersection and box areas are products of two sizes; the union can be
  // one bit wider. The ratio carries one integer bit so that 1.0 fits.
  localparam int unsigned PW = 2 * (COORD_BITS - 1);
  localparam int unsigned UW = PW + 1;
  localparam int unsigned RW = FRACTION_BITS + 1;

  logic [PW-1:0] inter;
  logic [UW-1:0] union_sum;

  // Chain links: entry 0 is fed by the front end, entry RW is the last
  // cell's registered output, which is also the output register.
  iou_tag_t      tag_c   [RW+1];
  logic          ready_c [RW+1];
  logic [UW-1:0] rem_c   [RW+1];
  logic [UW-1:0] den_c   [RW+1];
  logic [RW-1:0] q_c     [RW+1];

  // The front end works out the overlap, the areas and the union, and marks
  // a pair whose union is empty so that the ratio can be forced to zero.
  iou_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair_i),
    .tag_o       (tag_c[0]),
    .ready_i     (ready_c[0]),
    .inter_o     (inter),
    .union_sum_o (union_sum)
  );

  // The division starts with the intersection as the partial remainder and
  // the union as divisor. The intersection never exceeds the union, so the
  // integer part is a single bit and the whole quotient needs RW cells.
  assign rem_c[0] = UW'(inter);
  assign den_c[0] = union_sum;
  assign q_c[0]   = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    iou_div_cell #(
      .REM_BITS   (UW),
      .RATIO_BITS (RW),
      .FIRST_STEP (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tag_i   (tag_c[i]),
      .ready_o (ready_c[i]),
      .rem_i   (rem_c[i]),
      .den_i   (den_c[i]),
      .q_i     (q_c[i]),
      .tag_o   (tag_c[i+1]),
      .ready_i (ready_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .den_o   (den_c[i+1]),
      .q_o     (q_c[i+1])
    );
  end

  // Each stage takes a new word whenever it is empty or its own word moves
  // on, so a waiting result only holds back the stages behind it that are
  // full.
  assign ready_c[RW]            = result_o.ready;
  assign result_o.valid         = tag_c[RW].valid;
  assign result_o.union_empty   = tag_c[RW].empty;
  // With an empty union the divider has run against zero and its quotient is
  // meaningless, so the ratio is forced to zero.
  assign result_o.overlap_ratio = tag_c[RW].empty ? '0 : q_c[RW];

  a_ratio_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.overlap_ratio <= (RW'(1) << FRACTION_BITS)))
    else $error("ratio above one");

  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pair_i.ready |-> result_o.valid)
    else $error("input stalled while the output register is empty");

  a_last_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_c[RW].valid && !tag_c[RW].empty) |-> (rem_c[RW] < den_c[RW]))
    else $error("final remainder not below union");

endmodule

`default_nettype wire

// ===== bench/iou_result_checker.sv =====
// Result checker for the box intersection-over-union block: predicts the
// ratio word of every accepted box pair and compares the words that come out.
// Depends on iou_pkg and the channel interfaces in iou_if.
`timescale 1ns / 100ps

module iou_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  iou_in_if           pair_i,
  iou_out_if          result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned CoordBits    = iou_pkg::COORD_BITS_DEF;
  localparam int unsigned FractionBits = iou_pkg::FRACTION_BITS_DEF;

  typedef struct packed {
    logic [FractionBits:0] ratio;
    logic                  empty;
  } ratio_word_t;

  ratio_word_t ratio_words_due[$];

  // Overlap of two spans on one axis, zero when they only touch or miss.
  function automatic longint span_overlap(input logic signed [CoordBits-1:0] a_start,
                                          input logic [CoordBits-2:0] a_len,
                                          input logic signed [CoordBits-1:0] b_start,
                                          input logic [CoordBits-2:0] b_len);
    longint a_lo, a_hi, b_lo, b_hi, lo, hi;
    a_lo = longint'(a_start);
    b_lo = longint'(b_start);
    a_hi = a_lo + longint'({1'b0, a_len});
    b_hi = b_lo + longint'({1'b0, b_len});
    lo = (a_lo > b_lo) ? a_lo : b_lo;
    hi = (a_hi < b_hi) ? a_hi : b_hi;
    return (hi > lo) ? hi - lo : 64'sd0;
  endfunction

  function automatic ratio_word_t predict_ratio();
    ratio_word_t word;
    longint      inter, area_a, area_b, area_union;
    inter = span_overlap(pair_i.first_left, pair_i.first_width,
                         pair_i.second_left, pair_i.second_width) *
            span_overlap(pair_i.first_top, pair_i.first_height,
                         pair_i.second_top, pair_i.second_height);
    area_a = longint'({1'b0, pair_i.first_width}) * longint'({1'b0, pair_i.first_height});
    area_b = longint'({1'b0, pair_i.second_width}) * longint'({1'b0, pair_i.second_height});
    area_union = area_a + area_b - inter;
    if (area_union == 0) begin
      word.ratio = '0;
      word.empty = 1'b1;
    end else begin
      // Truncating division of the intersection scaled by the fraction bits.
      word.ratio = (FractionBits + 1)'((inter << FractionBits) / area_union);
      word.empty = 1'b0;
    end
    return word;
  endfunction

  int unsigned fail_count = 0;

  always @(posedge clk_i) begin : watch
    ratio_word_t due;
    if (rst_ni) begin
      if (result_i.valid && result_i.ready) begin
        if (ratio_words_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, ratio %0d empty %0b", $time,
                   result_i.overlap_ratio, result_i.union_empty);
        end else begin
          due = ratio_words_due.pop_front();
          if (result_i.overlap_ratio !== due.ratio) begin
            fail_count++;
            $display("%0t: overlap_ratio expected %0d, got %0d", $time,
                     due.ratio, result_i.overlap_ratio);
          end
          if (result_i.union_empty !== due.empty) begin
            fail_count++;
            $display("%0t: union_empty expected %0b, got %0b", $time,
                     due.empty, result_i.union_empty);
          end
        end
      end
      if (pair_i.valid && pair_i.ready) begin
        ratio_words_due = {ratio_words_due, predict_ratio()};
      end
    end
    fail_count_o = fail_count;
    pending_o    = ratio_words_due.size();
  end

endmodule

// ===== bench/box_intersection_over_union_tb.sv =====
// Testbench top for the box intersection-over-union block: drives box pairs
// and output back-pressure, and gives the verdict from the result checker.
// Depends on iou_pkg, iou_if, the block itself and iou_result_checker.
`timescale 1ns / 100ps

module box_intersection_over_union_tb;

  localparam int unsigned CoordBits  = iou_pkg::COORD_BITS_DEF;
  // Pipeline depth of the block: three front stages and one cell per
  // quotient bit.
  localparam int unsigned PipeDepth  = iou_pkg::FRACTION_BITS_DEF + 4;
  localparam int unsigned RandomPairs = 2000;
  // Far beyond the length of the slowest honest run.
  localparam int unsigned CycleLimit = 200_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  // While set, neither the sender nor the receiver inserts idle cycles.
  logic        steady_flow = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned words_pending;

  iou_in_if  pair_if ();
  iou_out_if result_if ();

  box_intersection_over_union u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair_if),
    .result_o (result_if)
  );

  iou_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (words_pending)
  );

  always #1 clk_i = ~clk_i;

  // A hung handshake ends the run here rather than letting it spin forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver holds off about 30 percent of the time, except during the
  // steady stretch. Ready only rises once reset has been released.
  always @(negedge clk_i) begin
    result_if.ready <= rst_ni && (steady_flow || ($urandom_range(99) >= 30));
  end

  // Presents one box pair at a falling edge and holds it until the block
  // takes the word. Any idle cycles come first, with valid low, so valid is
  // never dropped and raised again in the same step.
  task automatic offer_box_pair(input logic signed [CoordBits-1:0] l1,
                                input logic signed [CoordBits-1:0] t1,
                                input logic [CoordBits-2:0] w1,
                                input logic [CoordBits-2:0] h1,
                                input logic signed [CoordBits-1:0] l2,
                                input logic signed [CoordBits-1:0] t2,
                                input logic [CoordBits-2:0] w2,
                                input logic [CoordBits-2:0] h2);
    int unsigned idle_cycles;
    idle_cycles = 0;
    if (!steady_flow) begin
      while ($urandom_range(99) < 30) idle_cycles++;
    end
    @(negedge clk_i);
    if (idle_cycles > 0) begin
      pair_if.valid <= 1'b0;
      repeat (idle_cycles) @(negedge clk_i);
    end
    pair_if.valid         <= 1'b1;
    pair_if.first_left    <= l1;
    pair_if.first_top     <= t1;
    pair_if.first_width   <= w1;
    pair_if.first_height  <= h1;
    pair_if.second_left   <= l2;
    pair_if.second_top    <= t2;
    pair_if.second_width  <= w2;
    pair_if.second_height <= h2;
    do @(posedge clk_i); while (!pair_if.ready);
  endtask

  // Box sizes spread over every magnitude, so that small boxes are common
  // but the full range is still reached.
  function automatic logic [CoordBits-2:0] random_size();
    int unsigned span_bits;
    span_bits = $urandom_range(CoordBits - 1, 0);
    return (CoordBits - 1)'($urandom & ((32'd1 << span_bits) - 1));
  endfunction

  // Random pairs are mostly overlapping, since disjoint boxes only ever give
  // a zero ratio. The rest are copies, fully random pairs and tiny boxes
  // near the origin, which find the touching and zero-area cases.
  task automatic offer_random_pair();
    int unsigned                  mix;
    int                           reach, dx, dy;
    logic signed [CoordBits-1:0]  l1, t1, l2, t2;
    logic        [CoordBits-2:0]  w1, h1, w2, h2;
    mix = $urandom_range(99);
    l1 = CoordBits'($urandom);
    t1 = CoordBits'($urandom);
    w1 = random_size();
    h1 = random_size();
    if (mix < 15) begin
      l2 = l1;
      t2 = t1;
      w2 = w1;
      h2 = h1;
    end else if (mix < 70) begin
      reach = int'(w1) + 2;
      dx = int'($urandom_range(unsigned'(2 * reach))) - reach;
      reach = int'(h1) + 2;
      dy = int'($urandom_range(unsigned'(2 * reach))) - reach;
      l2 = CoordBits'(l1 + dx);
      t2 = CoordBits'(t1 + dy);
      w2 = $urandom_range(1) ? w1 : (CoordBits - 1)'(int'(w1) + int'($urandom_range(8)) - 4);
      h2 = $urandom_range(1) ? h1 : random_size();
    end else if (mix < 85) begin
      w1 = (CoordBits - 1)'($urandom);
      h1 = (CoordBits - 1)'($urandom);
      l2 = CoordBits'($urandom);
      t2 = CoordBits'($urandom);
      w2 = (CoordBits - 1)'($urandom);
      h2 = (CoordBits - 1)'($urandom);
    end else begin
      l1 = CoordBits'(int'($urandom_range(16)) - 8);
      t1 = CoordBits'(int'($urandom_range(16)) - 8);
      l2 = CoordBits'(int'($urandom_range(16)) - 8);
      t2 = CoordBits'(int'($urandom_range(16)) - 8);
      w1 = (CoordBits - 1)'($urandom_range(4));
      h1 = (CoordBits - 1)'($urandom_range(4));
      w2 = (CoordBits - 1)'($urandom_range(4));
      h2 = (CoordBits - 1)'($urandom_range(4));
    end
    offer_box_pair(l1, t1, w1, h1, l2, t2, w2, h2);
  endtask

  initial begin
    rst_ni                = 1'b0;
    pair_if.valid         = 1'b0;
    pair_if.first_left    = '0;
    pair_if.first_top     = '0;
    pair_if.first_width   = '0;
    pair_if.first_height  = '0;
    pair_if.second_left   = '0;
    pair_if.second_top    = '0;
    pair_if.second_width  = '0;
    pair_if.second_height = '0;
    result_if.ready       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identical boxes of the largest size at both ends of the coordinate
    // range, and with every input bit set: the ratio is exactly one.
    offer_box_pair(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767,
                   -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
    offer_box_pair(16'sd32767, 16'sd32767, 15'd32767, 15'd32767,
                   16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
    offer_box_pair(-16'sd1, -16'sd1, 15'h7fff, 15'h7fff,
                   -16'sd1, -16'sd1, 15'h7fff, 15'h7fff);
    // Empty union: all zero, then two flat boxes of zero area.
    offer_box_pair('0, '0, '0, '0, '0, '0, '0, '0);
    offer_box_pair(16'sd0, 16'sd0, 15'd0, 15'd9, 16'sd5, 16'sd5, 15'd0, 15'd40);
    offer_box_pair(16'sd3, 16'sd3, 15'd7, 15'd0, 16'sd3, 16'sd3, 15'd0, 15'd7);
    // Zero-size box against a real one, also lying inside it.
    offer_box_pair(16'sd0, 16'sd0, 15'd0, 15'd0, 16'sd0, 16'sd0, 15'd10, 15'd10);
    offer_box_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd5, 16'sd5, 15'd0, 15'd7);
    // Disjoint boxes, and boxes that only share an edge.
    offer_box_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd20, 16'sd20, 15'd10, 15'd10);
    offer_box_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd10, 16'sd0, 15'd10, 15'd10);
    offer_box_pair(16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd0, -16'sd10, 15'd10, 15'd10);
    // Largest boxes at opposite corners never meet.
    offer_box_pair(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767,
                   16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
    offer_box_pair(16'sd32767, -16'sd32768, 15'd32767, 15'd32767,
                   -16'sd32768, 16'sd32767, 15'd32767, 15'd32767);
    // One box inside another gives a quarter; a third needs truncation.
    offer_box_pair(16'sd0, 16'sd0, 15'd100, 15'd100, 16'sd25, 16'sd25, 15'd50, 15'd50);
    offer_box_pair(16'sd0, 16'sd0, 15'd2, 15'd1, 16'sd1, 16'sd0, 15'd2, 15'd1);
    // Overlap across the origin with negative corners.
    offer_box_pair(-16'sd10, -16'sd10, 15'd20, 15'd20, -16'sd5, -16'sd5, 15'd20, 15'd20);
    // Huge boxes sharing a single pixel: the ratio truncates to zero.
    offer_box_pair(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767,
                   -16'sd2, -16'sd2, 15'd32767, 15'd32767);
    // Nearly identical huge boxes, and a single pixel inside a huge box.
    offer_box_pair(16'sd0, 16'sd0, 15'd32767, 15'd32767, 16'sd1, 16'sd0, 15'd32767, 15'd32767);
    offer_box_pair(16'sd0, 16'sd0, 15'd32767, 15'd32767, 16'sd100, 16'sd100, 15'd1, 15'd1);
    // The second box contains the first, so the order of the pair is swapped.
    offer_box_pair(16'sd25, 16'sd25, 15'd50, 15'd50, 16'sd0, 16'sd0, 15'd100, 15'd100);

    for (int n = 0; n < RandomPairs; n++) begin
      steady_flow = (n >= 900) && (n < 1200);
      offer_random_pair();
    end
    steady_flow = 1'b0;

    @(negedge clk_i);
    pair_if.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    // Let any stray word that the block might still emit come out.
    repeat (PipeDepth + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== box_intersection_over_union.f =====
src/iou_pkg.sv
src/iou_if.sv
src/iou_front.sv
src/iou_div_cell.sv
src/box_intersection_over_union.sv
bench/iou_result_checker.sv
bench/box_intersection_over_union_tb.sv
